// ===== design/ppt_pkg.sv =====
package ppt_pkg;

  // input command codes (carried on in_tuser)
  localparam int CMD_W = 3;
  localparam logic [CMD_W-1:0] CMD_FRAME_BEGIN = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PACKET      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FRAME_END   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LOCAL_JOIN  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SET_READY   = 3'd4;

  // received packet types
  localparam logic [7:0] PKT_JOIN       = 8'd0;
  localparam logic [7:0] PKT_UPDATE     = 8'd1;
  localparam logic [7:0] PKT_READY      = 8'd2;
  localparam logic [7:0] PKT_CAR_UPDATE = 8'd3;
  localparam logic [7:0] PKT_DISCONNECT = 8'd4;

  localparam logic [7:0] PROTO_VERSION = 8'd1;

  // packet types requested for sending
  localparam logic [1:0] SEND_JOIN   = 2'd0;
  localparam logic [1:0] SEND_UPDATE = 2'd1;
  localparam logic [1:0] SEND_READY  = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MY_ID        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT_MS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS   = 2'd3;
  localparam int CFG_DATA_W = 16;

  // register reset values
  localparam logic [2:0]  MY_ID_RST        = 3'd0;
  localparam logic [7:0]  FRAME_MS_RST     = 8'd16;
  localparam logic [15:0] HEARTBEAT_MS_RST = 16'd1000;
  localparam logic [15:0] TIMEOUT_MS_RST   = 16'd3000;

  localparam int MIN_PEERS = 2;
  localparam int TIME_W    = 32;
  localparam int CNT_OUT_W = 4;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  // one result transaction
  typedef struct packed {
    logic                 all_ready;
    logic [CNT_OUT_W-1:0] connected_count;
    logic [7:0]           ready_mask;
    logic [7:0]           connected_mask;
    logic                 accepted;
    logic                 send_ready;
    logic [1:0]           send_type;
    logic                 send_valid;
  } result_t;

endpackage

// ===== design/ppt_ram.sv =====
module ppt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/peer_presence_tracker.sv =====
// S_IDLE latches an input transaction and S_EXEC works on it; a frame begin then checks the
// heartbeat in S_TICK, a frame end sweeps the slots in S_SWEEP (one last-seen RAM read per
// slot, pipelined with the timeout compare) and S_DRAIN, and S_DONE registers the result once
// the output is free. One item at a time; the next is taken the cycle after it is registered.
// Reset (rst_n low, synchronous): config back to defaults, clock and flags cleared, no
// result pending. The last-seen RAM is not cleared: it is only used for connected slots.
module peer_presence_tracker #(
  parameter int PLAYERS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ppt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppt_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [7:0] pkt_version, [15:8] pkt_type, [23:16] pkt_player, [24] ready_flag, rest zero
  input  logic [ppt_pkg::IN_DATA_W-1:0]     in_tdata,
  // [2:0] command
  input  logic [ppt_pkg::CMD_W-1:0]         in_tuser,
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] send_valid, [2:1] send_type, [3] send_ready, [4] accepted, [12:5] connected_mask,
  // [20:13] ready_mask, [24:21] connected_count, [25] all_ready, rest zero
  output logic [ppt_pkg::OUT_DATA_W-1:0]    out_tdata
);

  import ppt_pkg::*;

  localparam int IDX_W = $clog2(PLAYERS);
  localparam int CNT_W = $clog2(PLAYERS + 1);
  localparam int PAD_W = (PLAYERS >= 8) ? PLAYERS : 8;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PLAYERS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_TICK  = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [2:0]        my_id_r, my_id_nxt;
  logic [7:0]        frame_ms_r, frame_ms_nxt;
  logic [15:0]       hb_ms_r, hb_ms_nxt;
  logic [15:0]       to_ms_r, to_ms_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [TIME_W-1:0] last_bc_r, last_bc_nxt;
  logic [PLAYERS-1:0] conn_r, conn_nxt;
  logic [PLAYERS-1:0] rdy_r, rdy_nxt;
  logic [IDX_W-1:0]  sw_idx_r, sw_idx_nxt;
  logic [IDX_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic              chk_v_r, chk_v_nxt;
  logic              out_v_r, out_v_nxt;
  result_t           out_res_r, out_res_nxt;

  // latched input transaction
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [7:0]        ver_r, ver_nxt;
  logic [7:0]        ptype_r, ptype_nxt;
  logic [7:0]        player_r, player_nxt;
  logic              rflag_r, rflag_nxt;

  // result fields built up while the item is worked on
  logic              res_sv_r, res_sv_nxt;
  logic [1:0]        res_st_r, res_st_nxt;
  logic              res_sr_r, res_sr_nxt;
  logic              res_acc_r, res_acc_nxt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [TIME_W-1:0] ram_wdata;
  logic [TIME_W-1:0] ram_rdata;

  logic              own_valid;
  logic [IDX_W-1:0]  own_idx;
  logic              own_ready;
  logic              pkt_ok;
  logic [IDX_W-1:0]  pkt_idx;
  logic [CNT_W-1:0]  conn_cnt;
  logic [PAD_W-1:0]  conn_pad, rdy_pad;

  ppt_ram #(
    .WIDTH (TIME_W),
    .DEPTH (PLAYERS)
  ) u_last_seen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (sw_idx_r),
    .rdata (ram_rdata)
  );

  assign own_valid = 32'(my_id_r) < PLAYERS;
  assign own_idx   = IDX_W'(my_id_r);
  assign own_ready = own_valid & rdy_r[own_idx];
  assign pkt_idx   = IDX_W'(player_r);
  assign pkt_ok    = (ver_r == PROTO_VERSION) && (32'(player_r) < PLAYERS) &&
                     (player_r != 8'(my_id_r));

  assign conn_pad = PAD_W'(conn_r);
  assign rdy_pad  = PAD_W'(rdy_r);

  always_comb begin
    conn_cnt = '0;
    for (int i = 0; i < PLAYERS; i++) begin
      conn_cnt = conn_cnt + CNT_W'(conn_r[i]);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    my_id_nxt    = my_id_r;
    frame_ms_nxt = frame_ms_r;
    hb_ms_nxt    = hb_ms_r;
    to_ms_nxt    = to_ms_r;
    now_nxt      = now_r;
    last_bc_nxt  = last_bc_r;
    conn_nxt     = conn_r;
    rdy_nxt      = rdy_r;
    sw_idx_nxt   = sw_idx_r;
    chk_idx_nxt  = chk_idx_r;
    chk_v_nxt    = chk_v_r;
    out_v_nxt    = out_v_r;
    out_res_nxt  = out_res_r;
    cmd_nxt      = cmd_r;
    ver_nxt      = ver_r;
    ptype_nxt    = ptype_r;
    player_nxt   = player_r;
    rflag_nxt    = rflag_r;
    res_sv_nxt   = res_sv_r;
    res_st_nxt   = res_st_r;
    res_sr_nxt   = res_sr_r;
    res_acc_nxt  = res_acc_r;
    ram_we       = 1'b0;
    ram_waddr    = own_idx;
    ram_wdata    = now_r;

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MY_ID:        my_id_nxt    = cfg_data[2:0];
        CFG_FRAME_MS:     frame_ms_nxt = cfg_data[7:0];
        CFG_HEARTBEAT_MS: hb_ms_nxt    = cfg_data;
        CFG_TIMEOUT_MS:   to_ms_nxt    = cfg_data;
        default: ;
      endcase
    end

    if (out_tready) begin
      out_v_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt     = in_tuser;
          ver_nxt     = in_tdata[7:0];
          ptype_nxt   = in_tdata[15:8];
          player_nxt  = in_tdata[23:16];
          rflag_nxt   = in_tdata[24];
          res_sv_nxt  = 1'b0;
          res_st_nxt  = SEND_JOIN;
          res_sr_nxt  = 1'b0;
          res_acc_nxt = 1'b0;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (cmd_r)
          CMD_FRAME_BEGIN: begin
            now_nxt   = now_r + TIME_W'(frame_ms_r);
            state_nxt = S_TICK;
          end
          CMD_PACKET: begin
            if (pkt_ok) begin
              res_acc_nxt = 1'b1;
              ram_waddr   = pkt_idx;
              case (ptype_r) inside
                PKT_JOIN: begin
                  conn_nxt[pkt_idx] = 1'b1;
                  rdy_nxt[pkt_idx]  = 1'b0;
                  ram_we            = 1'b1;
                end
                PKT_UPDATE, PKT_READY: begin
                  conn_nxt[pkt_idx] = 1'b1;
                  rdy_nxt[pkt_idx]  = rflag_r;
                  ram_we            = 1'b1;
                end
                PKT_DISCONNECT: begin
                  conn_nxt[pkt_idx] = 1'b0;
                  rdy_nxt[pkt_idx]  = 1'b0;
                end
                // car updates and unknown types leave the table alone
                default: ;
              endcase
            end
          end
          CMD_FRAME_END: begin
            sw_idx_nxt = '0;
            state_nxt  = S_SWEEP;
          end
          CMD_LOCAL_JOIN: begin
            conn_nxt = '0;
            rdy_nxt  = '0;
            if (own_valid) begin
              conn_nxt[own_idx] = 1'b1;
              ram_we            = 1'b1;
            end
            last_bc_nxt = now_r;
            res_sv_nxt  = 1'b1;
            res_st_nxt  = SEND_JOIN;
          end
          CMD_SET_READY: begin
            if (own_valid) begin
              rdy_nxt[own_idx] = rflag_r;
            end
            res_sv_nxt = 1'b1;
            res_st_nxt = SEND_READY;
            res_sr_nxt = rflag_r;
          end
          default: ;
        endcase
      end
      S_TICK: begin
        if ((now_r - last_bc_r) >= TIME_W'(hb_ms_r)) begin
          res_sv_nxt  = 1'b1;
          res_st_nxt  = SEND_UPDATE;
          res_sr_nxt  = own_ready;
          last_bc_nxt = now_r;
          ram_we      = own_valid;
        end
        state_nxt = S_DONE;
      end
      S_SWEEP: begin
        // read slot sw_idx now, check it next cycle
        chk_v_nxt   = 1'b1;
        chk_idx_nxt = sw_idx_r;
        if (sw_idx_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end else begin
          sw_idx_nxt = sw_idx_r + 1'b1;
        end
      end
      S_DRAIN: begin
        chk_v_nxt = 1'b0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_v_r || out_tready) begin
          out_v_nxt                   = 1'b1;
          out_res_nxt.send_valid      = res_sv_r;
          out_res_nxt.send_type       = res_st_r;
          out_res_nxt.send_ready      = res_sr_r;
          out_res_nxt.accepted        = res_acc_r;
          out_res_nxt.connected_mask  = conn_pad[7:0];
          out_res_nxt.ready_mask      = rdy_pad[7:0];
          out_res_nxt.connected_count = (32'(conn_cnt) > 15) ? 4'd15 : CNT_OUT_W'(conn_cnt);
          out_res_nxt.all_ready       = (32'(conn_cnt) >= MIN_PEERS) &&
                                        ((conn_r & ~rdy_r) == '0);
          state_nxt                   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // timeout check for the slot read in the previous cycle; own slot is never dropped
    if (chk_v_r && (8'(chk_idx_r) != 8'(my_id_r)) && conn_r[chk_idx_r] &&
        ((now_r - ram_rdata) > TIME_W'(to_ms_r))) begin
      conn_nxt[chk_idx_r] = 1'b0;
      rdy_nxt[chk_idx_r]  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      my_id_r    <= MY_ID_RST;
      frame_ms_r <= FRAME_MS_RST;
      hb_ms_r    <= HEARTBEAT_MS_RST;
      to_ms_r    <= TIMEOUT_MS_RST;
      now_r      <= '0;
      last_bc_r  <= '0;
      conn_r     <= '0;
      rdy_r      <= '0;
      sw_idx_r   <= '0;
      chk_v_r    <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      my_id_r    <= my_id_nxt;
      frame_ms_r <= frame_ms_nxt;
      hb_ms_r    <= hb_ms_nxt;
      to_ms_r    <= to_ms_nxt;
      now_r      <= now_nxt;
      last_bc_r  <= last_bc_nxt;
      conn_r     <= conn_nxt;
      rdy_r      <= rdy_nxt;
      sw_idx_r   <= sw_idx_nxt;
      chk_v_r    <= chk_v_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= chk_idx_nxt;
    out_res_r <= out_res_nxt;
    cmd_r     <= cmd_nxt;
    ver_r     <= ver_nxt;
    ptype_r   <= ptype_nxt;
    player_r  <= player_nxt;
    rflag_r   <= rflag_nxt;
    res_sv_r  <= res_sv_nxt;
    res_st_r  <= res_st_nxt;
    res_sr_r  <= res_sr_nxt;
    res_acc_r <= res_acc_nxt;
  end

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_DATA_W'(out_res_r);

`ifndef SYNTH
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second transaction taken while one is in flight");

  a_ram_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_EXEC || state_r == S_TICK))
    else $error("last-seen write outside command execution");

  a_sweep_keeps_own: assert property (@(posedge clk) disable iff (!rst_n)
    (chk_v_r && own_valid && (chk_idx_r == own_idx)) |=>
      (conn_r[$past(own_idx)] == $past(conn_r[own_idx])))
    else $error("sweep changed own slot");

  a_sweep_only_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    chk_v_r |-> (state_r == S_SWEEP || state_r == S_DRAIN))
    else $error("timeout check active outside sweep");

  a_all_ready_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_res_r.all_ready) |-> (out_res_r.connected_count >= 4'd2))
    else $error("all_ready with fewer than two peers");
`endif

endmodule
